// File: rtl/vnf_pkg.sv
// vnf_pkg: shared types and constants of the value noise field generator
// lattice hash constants, fixed-point widths, register indexes, config bundle
// no dependencies
package vnf_pkg;

  // input coordinate widths
  localparam int unsigned CX_W = 6;
  localparam int unsigned CY_W = 5;

  // fixed-point widths
  localparam int unsigned FRQ_W = 16;
  localparam int unsigned NZ_W  = 16;
  localparam int unsigned LVL_W = 19;
  localparam int unsigned FX_W  = CX_W + FRQ_W;
  localparam int unsigned FY_W  = CY_W + FRQ_W;

  // lattice hash multipliers
  localparam logic [31:0] HASH_X = 32'd374761393;
  localparam logic [31:0] HASH_Y = 32'd668265263;
  localparam logic [31:0] HASH_S = 32'd2246822519;
  localparam logic [31:0] HASH_M = 32'd1274126177;

  // octave mix weights, 0.65 and 0.35 in Q0.16
  localparam logic [15:0] MIX_COARSE = 16'd42598;
  localparam logic [15:0] MIX_FINE   = 16'd22938;

  // fine octave seed offset
  localparam logic [31:0] SEED_OFS = 32'd99;

  // smoothstep constant 3.0 in Q.16
  localparam logic [17:0] THREE_Q16 = 18'd196608;

  // register reset values
  localparam logic [31:0]      SEED_RST   = 32'd20260628;
  localparam logic [FRQ_W-1:0] COARSE_RST = 16'd7864;
  localparam logic [FRQ_W-1:0] FINE_RST   = 16'd19661;
  localparam logic [LVL_W-1:0] PEAK_RST   = 19'd327680;

  // seed products of the reset seed
  localparam logic [31:0] TERM_C_RST = 32'(64'(SEED_RST) * 64'(HASH_S));
  localparam logic [31:0] TERM_F_RST = 32'(64'(32'(SEED_RST + SEED_OFS)) * 64'(HASH_S));

  // register indexes of the config port
  typedef enum logic [1:0] {
    REG_SEED   = 2'd0,
    REG_COARSE = 2'd1,
    REG_FINE   = 2'd2,
    REG_PEAK   = 2'd3
  } cfg_reg_e;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [31:0]      term_c;  // seed times hash constant, coarse octave
    logic [31:0]      term_f;  // same for seed plus offset, fine octave
    logic [FRQ_W-1:0] coarse;
    logic [FRQ_W-1:0] fine;
    logic [LVL_W-1:0] peak;
  } cfg_t;

  // first half of the corner hash: sum of products and the first xor fold
  function automatic logic [31:0] hash_pre(input logic [CX_W-1:0] x,
                                           input logic [CY_W-1:0] y,
                                           input logic [31:0] s_term);
    logic [31:0] h;
    h = 32'(32'(x) * HASH_X) + 32'(32'(y) * HASH_Y) + s_term;
    return h ^ (h >> 13);
  endfunction

endpackage

// File: rtl/value_noise_field_generator.sv
// value_noise_field_generator: two-octave value noise, squared and scaled by a peak level
// one beat per cycle sustained while the output register is free or taken,
// through a ten-stage pipeline that stalls when its output register is full and not taken
// reset clears the pipeline valid bits and loads the register reset values;
// the seed products are registered from the seed register in the cycle after a seed write
// depends on vnf_pkg, vnf_cfg, vnf_lattice, vnf_interp
module value_noise_field_generator
  import vnf_pkg::*;
#(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cell_x [5:0], cell_y [10:6], zero pad
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // level [18:0], noise [34:19], zero pad
);

  localparam int unsigned NSTG = 10;

  cfg_t cfg;

  vnf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // pipeline advance and valid bits
  logic            en;
  logic [NSTG-1:0] vld_q;

  assign en            = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // clamp cells beyond the grid to its last row or column
  logic [CX_W-1:0] cx_raw, cx;
  logic [CY_W-1:0] cy_raw, cy;

  assign cx_raw = s_axis_tdata[CX_W-1:0];
  assign cy_raw = s_axis_tdata[CX_W+CY_W-1:CX_W];
  assign cx = (int'(cx_raw) >= GRID_WIDTH)  ? CX_W'(GRID_WIDTH - 1)  : cx_raw;
  assign cy = (int'(cy_raw) >= GRID_HEIGHT) ? CY_W'(GRID_HEIGHT - 1) : cy_raw;

  // two octaves, stages 1 to 7
  logic [1:0][3:0][NZ_W-1:0] corner;
  logic [1:0][NZ_W-1:0]      ux, uy, oct;
  logic [1:0][FRQ_W-1:0]     freq;
  logic [1:0][31:0]          s_term;

  assign freq[0]   = cfg.coarse;
  assign freq[1]   = cfg.fine;
  assign s_term[0] = cfg.term_c;
  assign s_term[1] = cfg.term_f;

  for (genvar o = 0; o < 2; o++) begin : g_oct
    vnf_lattice u_lat (
      .clk_i    (clk_i),
      .en_i     (en),
      .cx_i     (cx),
      .cy_i     (cy),
      .freq_i   (freq[o]),
      .s_term_i (s_term[o]),
      .corner_o (corner[o]),
      .ux_o     (ux[o]),
      .uy_o     (uy[o])
    );

    vnf_interp u_itp (
      .clk_i    (clk_i),
      .en_i     (en),
      .corner_i (corner[o]),
      .ux_i     (ux[o]),
      .uy_i     (uy[o]),
      .noise_o  (oct[o])
    );
  end

  // stage 8: octave mix
  logic [31:0]     mix_sum;
  logic [NZ_W-1:0] n8_q;

  assign mix_sum = 32'(oct[0]) * 32'(MIX_COARSE) + 32'(oct[1]) * 32'(MIX_FINE);

  always_ff @(posedge clk_i) begin
    if (en) begin
      n8_q <= mix_sum[31:16];
    end
  end

  // stage 9: square
  logic [31:0]     sq_prod;
  logic [NZ_W-1:0] sq_q, n9_q;

  assign sq_prod = n8_q * n8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q <= sq_prod[31:16];
      n9_q <= n8_q;
    end
  end

  // stage 10: peak scaling into the output register
  logic [NZ_W+LVL_W-1:0] lvl_prod;
  logic [LVL_W-1:0]      lvl_q;
  logic [NZ_W-1:0]       n10_q;

  assign lvl_prod = sq_q * cfg.peak;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lvl_q <= lvl_prod[NZ_W+LVL_W-1:16];
      n10_q <= n9_q;
    end
  end

  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = {5'd0, n10_q, lvl_q};

endmodule

// File: rtl/vnf_cfg.sv
// vnf_cfg: configuration registers and registered seed products
// depends on vnf_pkg
module vnf_cfg
  import vnf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  logic [31:0]      seed_q, term_c_q, term_f_q;
  logic [FRQ_W-1:0] coarse_q, fine_q;
  logic [LVL_W-1:0] peak_q;
  logic [31:0]      term_c_d, term_f_d;

  assign cfg_ready_o = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= SEED_RST;
      coarse_q <= COARSE_RST;
      fine_q   <= FINE_RST;
      peak_q   <= PEAK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SEED:   seed_q   <= cfg_data_i;
        REG_COARSE: coarse_q <= cfg_data_i[FRQ_W-1:0];
        REG_FINE:   fine_q   <= cfg_data_i[FRQ_W-1:0];
        REG_PEAK:   peak_q   <= cfg_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // seed products, registered in the cycle after the seed register
  assign term_c_d = 32'(seed_q * HASH_S);
  assign term_f_d = 32'((seed_q + SEED_OFS) * HASH_S);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_c_q <= TERM_C_RST;
      term_f_q <= TERM_F_RST;
    end else begin
      term_c_q <= term_c_d;
      term_f_q <= term_f_d;
    end
  end

  assign cfg_o = '{term_c: term_c_q, term_f: term_f_q, coarse: coarse_q,
                   fine: fine_q, peak: peak_q};

endmodule

// File: rtl/vnf_lattice.sv
// vnf_lattice: one octave, lattice coordinates, smoothstep weights, corner hashes
// three register stages; depends on vnf_pkg
module vnf_lattice
  import vnf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [CX_W-1:0]      cx_i,
  input  logic [CY_W-1:0]      cy_i,
  input  logic [FRQ_W-1:0]     freq_i,
  input  logic [31:0]          s_term_i,
  output logic [3:0][NZ_W-1:0] corner_o,  // c00, c10, c01, c11
  output logic [NZ_W-1:0]      ux_o,
  output logic [NZ_W-1:0]      uy_o
);

  // stage 1: scaled coordinates
  logic [FX_W-1:0] fx_d, fx_q;
  logic [FY_W-1:0] fy_d, fy_q;

  assign fx_d = FX_W'(cx_i) * FX_W'(freq_i);
  assign fy_d = FY_W'(cy_i) * FY_W'(freq_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_q <= fx_d;
      fy_q <= fy_d;
    end
  end

  // stage 2: squared fractions, smoothstep slopes, first hash half
  logic [CX_W-1:0]  x0;
  logic [CY_W-1:0]  y0;
  logic [15:0]      tx, ty;
  logic [31:0]      sqx, sqy;
  logic [15:0]      t2x_q, t2y_q;
  logic [17:0]      kx_d, ky_d, kx_q, ky_q;
  logic [3:0][31:0] hm_d, hm_q;

  assign x0  = fx_q[FX_W-1:16];
  assign y0  = fy_q[FY_W-1:16];
  assign tx  = fx_q[15:0];
  assign ty  = fy_q[15:0];
  assign sqx = tx * tx;
  assign sqy = ty * ty;
  assign kx_d = THREE_Q16 - {1'b0, tx, 1'b0};
  assign ky_d = THREE_Q16 - {1'b0, ty, 1'b0};

  // corner i sits at x0 + i[0], y0 + i[1]
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hm_d[i] = hash_pre(x0 + CX_W'(i & 1), y0 + CY_W'(i >> 1), s_term_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2x_q <= sqx[31:16];
      t2y_q <= sqy[31:16];
      kx_q  <= kx_d;
      ky_q  <= ky_d;
      hm_q  <= hm_d;
    end
  end

  // stage 3: smoothstep weights and corner values
  logic [33:0]          ssx, ssy;
  logic [3:0][31:0]     h2;
  logic [3:0][NZ_W-1:0] corner_q;
  logic [NZ_W-1:0]      ux_q, uy_q;

  assign ssx = t2x_q * kx_q;
  assign ssy = t2y_q * ky_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      h2[i] = 32'(hm_q[i] * HASH_M);
    end
  end

  // final fold leaves the top half of the product unchanged
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q <= ssx[31:16];
      uy_q <= ssy[31:16];
      for (int i = 0; i < 4; i++) begin
        corner_q[i] <= h2[i][31:16];
      end
    end
  end

  assign corner_o = corner_q;
  assign ux_o     = ux_q;
  assign uy_o     = uy_q;

endmodule

// File: rtl/vnf_interp.sv
// vnf_interp: bilinear blend of four corner values with smoothstep weights
// four register stages; depends on vnf_pkg
module vnf_interp
  import vnf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [3:0][NZ_W-1:0] corner_i,  // c00, c10, c01, c11
  input  logic [NZ_W-1:0]      ux_i,
  input  logic [NZ_W-1:0]      uy_i,
  output logic [NZ_W-1:0]      noise_o
);

  // stage 4: scaled differences along x for the top and bottom rows
  logic [1:0]           up_d, up_q;
  logic [1:0][NZ_W-1:0] mag, base_q, step_q;
  logic [1:0][31:0]     prod;
  logic [NZ_W-1:0]      uy4_q;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      up_d[r] = corner_i[2*r+1] >= corner_i[2*r];
      mag[r]  = up_d[r] ? corner_i[2*r+1] - corner_i[2*r]
                        : corner_i[2*r] - corner_i[2*r+1];
      prod[r] = mag[r] * ux_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      up_q  <= up_d;
      uy4_q <= uy_i;
      for (int r = 0; r < 2; r++) begin
        base_q[r] <= corner_i[2*r];
        step_q[r] <= prod[r][31:16];
      end
    end
  end

  // stage 5: top and bottom row values
  logic [1:0][NZ_W-1:0] row_d, row_q;
  logic [NZ_W-1:0]      uy5_q;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      row_d[r] = up_q[r] ? base_q[r] + step_q[r] : base_q[r] - step_q[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
      uy5_q <= uy4_q;
    end
  end

  // stage 6: scaled difference along y
  logic            upy_d, upy_q;
  logic [NZ_W-1:0] magy, top6_q, stepy_q;
  logic [31:0]     prody;

  assign upy_d = row_q[1] >= row_q[0];
  assign magy  = upy_d ? row_q[1] - row_q[0] : row_q[0] - row_q[1];
  assign prody = magy * uy5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      upy_q   <= upy_d;
      top6_q  <= row_q[0];
      stepy_q <= prody[31:16];
    end
  end

  // stage 7: octave value
  logic [NZ_W-1:0] noise_d, noise_q;

  assign noise_d = upy_q ? top6_q + stepy_q : top6_q - stepy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      noise_q <= noise_d;
    end
  end

  assign noise_o = noise_q;

endmodule
